// ===== rtl/core/ttu_pkg.sv =====
// Shared constants, codes and controller/datapath types of the transposition table unit.
package ttu_pkg;

	localparam int BUCKETS_DEF   = 1024;
	localparam int MOVE_BITS_DEF = 16;
	localparam int KEY_W         = 64;
	localparam int HASH_BPC      = 4;
	localparam int HASH_STEPS    = KEY_W / HASH_BPC;
	localparam int PERMILLE      = 1000;
	localparam int INF_W         = 15;
	localparam logic [INF_W-1:0] INF_RESET = 15'd32000;

	localparam logic [2:0] OP_PROBE  = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_STORE  = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_OCC    = 3'd4;

	localparam logic [1:0] BND_EMPTY = 2'd0;
	localparam logic [1:0] BND_EXACT = 2'd1;
	localparam logic [1:0] BND_UPPER = 2'd2;
	localparam logic [1:0] BND_LOWER = 2'd3;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_HASH, ST_READ, ST_EVAL, ST_CLEAR, ST_OCC
	} state_t;

	typedef struct packed {
		logic capture;
		logic hash_step;
		logic mem_rd;
		logic eval;
		logic sweep;
		logic occ_out;
	} cmd_t;

	typedef struct packed {
		logic       hash_last;
		logic       sweep_last;
		logic       out_free;
		logic [2:0] op;
	} stat_t;

endpackage

// ===== rtl/core/two_way_transposition_table_unit.sv =====
// Top level of the two-way transposition table unit.
// Each bucket holds two ways in one memory row. After reset the unit clears the memory
// before s_tready first rises; a clear command likewise clears every row, and no input is
// accepted meanwhile. Probe, move lookup and store run in steps: the transfer, the
// reduction of the 64-bit key modulo BUCKETS four bits at a time, the bucket row read,
// and the evaluation, which for a store writes the row back; a probe or move lookup stays
// in that last step while an earlier result has not been taken. An occupancy query needs
// no scan of the table, since the permille figure is kept up to date as ways fill and empty;
// it also waits while an earlier result has not been taken. Results sit in an output
// register, so a new transfer can be accepted while a result waits to be taken.
module two_way_transposition_table_unit #(
	parameter int BUCKETS   = ttu_pkg::BUCKETS_DEF,
	parameter int MOVE_BITS = ttu_pkg::MOVE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// key[63:0], depth[71:64], ply[79:72], alpha[95:80], beta[111:96], value[127:112],
	// bound_type[129:128], move[145:130], zero fill above
	input  logic [151:0]              s_tdata,
	// operation[2:0]
	input  logic [2:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// score[15:0], best_move[31:16], occupancy_permille[41:32], zero fill above
	output logic [47:0]               m_tdata,
	// hit
	output logic                      m_tuser,
	input  logic                      cfg_we,
	input  logic [ttu_pkg::INF_W-1:0] cfg_wdata
);

	ttu_pkg::cmd_t  cmd;
	ttu_pkg::stat_t stat;

	ttu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_op    (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ttu_dp #(
		.BUCKETS   (BUCKETS),
		.MOVE_BITS (MOVE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

`ifndef ASSERT_OFF
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == ttu_pkg::OP_CLEAR)) |=> !s_tready)
		else $error("input accepted during table clear");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[41:32] <= 10'd1000))
		else $error("occupancy above one thousand");

	a_store_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == ttu_pkg::OP_STORE)) |=> !$rose(m_tvalid))
		else $error("store produced a result");
`endif

endmodule

// ===== rtl/core/ttu_ctrl.sv =====
// Controller state machine of the transposition table unit.
module ttu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic [2:0]     in_op,
	output logic           s_tready,
	input  ttu_pkg::stat_t stat,
	output ttu_pkg::cmd_t  cmd
);

	ttu_pkg::state_t state_q, state_nx;
	logic            eval_ok;

	assign eval_ok = (stat.op == ttu_pkg::OP_STORE) || stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttu_pkg::ST_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ttu_pkg::ST_INIT: begin
				if (stat.sweep_last) state_nx = ttu_pkg::ST_IDLE;
			end
			ttu_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					unique case (in_op) inside
						ttu_pkg::OP_PROBE, ttu_pkg::OP_LOOKUP, ttu_pkg::OP_STORE: begin
							state_nx = ttu_pkg::ST_HASH;
						end
						ttu_pkg::OP_CLEAR: begin
							state_nx = ttu_pkg::ST_CLEAR;
						end
						ttu_pkg::OP_OCC: begin
							state_nx = ttu_pkg::ST_OCC;
						end
						default: begin
							state_nx = ttu_pkg::ST_IDLE;
						end
					endcase
				end
			end
			ttu_pkg::ST_HASH: begin
				if (stat.hash_last) state_nx = ttu_pkg::ST_READ;
			end
			ttu_pkg::ST_READ: begin
				state_nx = ttu_pkg::ST_EVAL;
			end
			ttu_pkg::ST_EVAL: begin
				if (eval_ok) state_nx = ttu_pkg::ST_IDLE;
			end
			ttu_pkg::ST_CLEAR: begin
				if (stat.sweep_last) state_nx = ttu_pkg::ST_IDLE;
			end
			ttu_pkg::ST_OCC: begin
				if (stat.out_free) state_nx = ttu_pkg::ST_IDLE;
			end
			default: begin
				state_nx = ttu_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ttu_pkg::ST_INIT:  cmd.sweep = 1'b1;
			ttu_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ttu_pkg::ST_HASH:  cmd.hash_step = 1'b1;
			ttu_pkg::ST_READ:  cmd.mem_rd = 1'b1;
			ttu_pkg::ST_EVAL:  cmd.eval = eval_ok;
			ttu_pkg::ST_CLEAR: cmd.sweep = 1'b1;
			ttu_pkg::ST_OCC:   cmd.occ_out = stat.out_free;
			default:           cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/ttu_dp.sv =====
// Datapath of the transposition table unit: bucket hash, table memory, entry logic, occupancy.
module ttu_dp #(
	parameter int BUCKETS   = ttu_pkg::BUCKETS_DEF,
	parameter int MOVE_BITS = ttu_pkg::MOVE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ttu_pkg::cmd_t             cmd,
	output ttu_pkg::stat_t            stat,
	input  logic [151:0]              s_tdata,
	input  logic [2:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata,
	output logic                      m_tuser,
	input  logic                      cfg_we,
	input  logic [ttu_pkg::INF_W-1:0] cfg_wdata
);

	localparam int KW     = ttu_pkg::KEY_W;
	localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SLOTS  = 2 * BUCKETS;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int PQ     = ttu_pkg::PERMILLE / SLOTS;
	localparam int PR     = ttu_pkg::PERMILLE % SLOTS;
	localparam int HCNT_W = $clog2(ttu_pkg::HASH_STEPS);
	localparam int ENT_W  = KW + 16 + MOVE_BITS + 8 + 2;
	localparam int ROW_W  = 2 * ENT_W;
	localparam int D_LO   = 2;
	localparam int S_LO   = 10;
	localparam int M_LO   = 26;
	localparam int K_LO   = 26 + MOVE_BITS;
	localparam logic [IDX_W:0]   BKT       = (IDX_W + 1)'(BUCKETS);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUCKETS - 1);
	localparam logic [CNT_W:0]   SLOTS_R   = (CNT_W + 1)'(SLOTS);
	localparam logic [CNT_W:0]   PR_R      = (CNT_W + 1)'(PR);
	localparam logic [9:0]       PQ_P      = 10'(PQ);

	logic [2:0]                op_q;
	logic [KW-1:0]             key_q, ksh_q;
	logic [7:0]                depth_q, ply_q;
	logic [15:0]               alpha_q, beta_q, value_q, move_q;
	logic [1:0]                bound_q;
	logic [ttu_pkg::INF_W-1:0] inf_q;
	logic [IDX_W-1:0]          idx_q, idx_nx, sweep_q;
	logic [HCNT_W-1:0]         hcnt_q;
	logic [ROW_W-1:0]          mem [BUCKETS];
	logic [ROW_W-1:0]          rd_q, wr_row;
	logic                      wr_en;
	logic [CNT_W:0]            prem_q, prem_up, prem_dn;
	logic                      prem_carry, prem_borrow;
	logic [9:0]                permille_q;
	logic                      out_valid_q, hit_q;
	logic [15:0]               score_q, best_q;
	logic [9:0]                occ_q;

	// Remainder of the key by the bucket count, a few key bits per cycle from the top.
	always_comb begin
		logic [IDX_W:0] hr;
		hr = (IDX_W + 1)'(idx_q);
		for (int i = 0; i < ttu_pkg::HASH_BPC; i++) begin
			hr = {hr[IDX_W-1:0], ksh_q[KW-1-i]};
			if (hr >= BKT) hr = hr - BKT;
		end
		idx_nx = hr[IDX_W-1:0];
	end

	logic [ENT_W-1:0] w0, w1, sel_e, new_e;
	logic [KW-1:0]    k0, k1;
	logic [1:0]       b0, sel_b;
	logic [7:0]       d0, sel_d;
	logic [15:0]      sel_s, st;
	logic [31:0]      sel_mv, mv_ext;
	logic             m0, m1, any_m, sel_inf, val_inf, p_hit, skip, use0, swap;
	logic signed [16:0] sc17, al17, be17;
	logic [16:0]      sum17;
	logic [15:0]      p_score, p_best;
	logic             new_nz, old_nz;

	assign w0    = rd_q[ENT_W-1:0];
	assign w1    = rd_q[ROW_W-1:ENT_W];
	assign k0    = w0[K_LO +: KW];
	assign k1    = w1[K_LO +: KW];
	assign b0    = w0[1:0];
	assign d0    = w0[D_LO +: 8];
	assign m0    = (k0 == key_q);
	assign m1    = (k1 == key_q);
	assign any_m = m0 || m1;
	assign sel_e = m0 ? w0 : w1;
	assign sel_b = sel_e[1:0];
	assign sel_d = sel_e[D_LO +: 8];
	assign sel_s = sel_e[S_LO +: 16];
	assign sel_mv = 32'(sel_e[M_LO +: MOVE_BITS]);

	assign sel_inf = !sel_s[15] && (sel_s[14:0] == inf_q);
	assign sc17    = {sel_s[15], sel_s} - (sel_inf ? {9'd0, ply_q} : 17'd0);
	assign al17    = {alpha_q[15], alpha_q};
	assign be17    = {beta_q[15], beta_q};

	always_comb begin
		p_hit = 1'b0;
		if (any_m && (op_q == ttu_pkg::OP_PROBE) && (sel_d >= depth_q)) begin
			p_hit = (sel_b == ttu_pkg::BND_EXACT)
				|| ((sel_b == ttu_pkg::BND_UPPER) && (sc17 <= al17))
				|| ((sel_b == ttu_pkg::BND_LOWER) && (sc17 >= be17));
		end
		p_score = p_hit ? sc17[15:0] : 16'd0;
		p_best  = any_m ? sel_mv[15:0] : 16'd0;
	end

	// Store: score adjustment, way choice and the depth-preferred swap into way 0.
	assign skip    = (ply_q != 8'd0) && (value_q == 16'd0);
	assign val_inf = !value_q[15] && (value_q[14:0] == inf_q);
	assign sum17   = {1'b0, value_q} + {9'd0, ply_q};
	assign mv_ext  = 32'(move_q);

	always_comb begin
		if (val_inf) begin
			st = (sum17 > 17'd32767) ? 16'h7fff : sum17[15:0];
		end else begin
			st = value_q;
		end
		new_e = {key_q, mv_ext[MOVE_BITS-1:0], st, depth_q, bound_q};
		use0  = (b0 == ttu_pkg::BND_EMPTY) || m0;
		swap  = !use0 && (depth_q > d0);
		if (use0) begin
			wr_row = {w1, new_e};
		end else if (swap) begin
			wr_row = {w0, new_e};
		end else begin
			wr_row = {new_e, w0};
		end
		new_nz = (key_q != '0);
		old_nz = use0 ? (k0 != '0) : (k1 != '0);
		if (cmd.sweep) wr_row = '0;
	end

	assign wr_en = cmd.sweep || (cmd.eval && (op_q == ttu_pkg::OP_STORE) && !skip);

	always_ff @(posedge clk) begin
		if (wr_en) mem[cmd.sweep ? sweep_q : idx_q] <= wr_row;
		if (cmd.mem_rd) rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= s_tuser;
			key_q   <= s_tdata[63:0];
			ksh_q   <= s_tdata[63:0];
			depth_q <= s_tdata[71:64];
			ply_q   <= s_tdata[79:72];
			alpha_q <= s_tdata[95:80];
			beta_q  <= s_tdata[111:96];
			value_q <= s_tdata[127:112];
			bound_q <= s_tdata[129:128];
			move_q  <= s_tdata[145:130];
		end else if (cmd.hash_step) begin
			ksh_q <= ksh_q << ttu_pkg::HASH_BPC;
		end
	end

	// The permille figure is kept as quotient and remainder of used ways * 1000 by the way
	// count; a way that fills or empties moves them by one compare and one correction.
	assign prem_up     = prem_q + PR_R;
	assign prem_dn     = prem_q - PR_R;
	assign prem_carry  = (prem_up >= SLOTS_R);
	assign prem_borrow = (prem_q < PR_R);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_q      <= ttu_pkg::INF_RESET;
			idx_q      <= '0;
			hcnt_q     <= '0;
			sweep_q    <= '0;
			prem_q     <= '0;
			permille_q <= '0;
		end else begin
			if (cfg_we) inf_q <= cfg_wdata;
			if (cmd.capture) begin
				idx_q  <= '0;
				hcnt_q <= '0;
			end else if (cmd.hash_step) begin
				idx_q  <= idx_nx;
				hcnt_q <= hcnt_q + 1'b1;
			end
			if (cmd.sweep) begin
				sweep_q    <= (sweep_q == LAST_IDX) ? '0 : sweep_q + 1'b1;
				prem_q     <= '0;
				permille_q <= '0;
			end else if (wr_en) begin
				if (new_nz && !old_nz) begin
					prem_q     <= prem_carry ? prem_up - SLOTS_R : prem_up;
					permille_q <= permille_q + PQ_P + {9'd0, prem_carry};
				end else if (!new_nz && old_nz) begin
					prem_q     <= prem_borrow ? prem_dn + SLOTS_R : prem_dn;
					permille_q <= permille_q - PQ_P - {9'd0, prem_borrow};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.eval && (op_q != ttu_pkg::OP_STORE)) || cmd.occ_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && (op_q != ttu_pkg::OP_STORE)) begin
			hit_q   <= p_hit;
			score_q <= p_score;
			best_q  <= p_best;
			occ_q   <= '0;
		end else if (cmd.occ_out) begin
			hit_q   <= 1'b0;
			score_q <= '0;
			best_q  <= '0;
			occ_q   <= permille_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {6'd0, occ_q, best_q, score_q};

	assign stat.hash_last  = (hcnt_q == HCNT_W'(ttu_pkg::HASH_STEPS - 1));
	assign stat.sweep_last = (sweep_q == LAST_IDX);
	assign stat.out_free   = !out_valid_q || m_tready;
	assign stat.op         = op_q;

endmodule

// ===== test/two_way_transposition_table_unit_test.sv =====
// Testbench of the two-way transposition table unit: random and directed traffic checked by a table model.
`timescale 1ns / 1ps

module two_way_transposition_table_unit_test;

	localparam int NBUCKETS = 1024;
	localparam int NSLOTS = 2 * NBUCKETS;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 1200;

	typedef struct {
		bit        hit;
		bit [15:0] score;
		bit [15:0] best_move;
		bit [9:0]  permille;
	} tt_answer_t;

	class tt_scoreboard;
		bit [63:0] keys[NSLOTS];
		int        scores[NSLOTS];
		bit [15:0] moves[NSLOTS];
		bit [7:0]  depths[NSLOTS];
		bit [1:0]  bounds[NSLOTS];
		int        infinity;
		tt_answer_t pending[$];
		int        errors;
		int        checked;

		function void wipe();
			foreach (keys[i]) begin
				keys[i] = '0;
				scores[i] = 0;
				moves[i] = '0;
				depths[i] = '0;
				bounds[i] = ttu_pkg::BND_EMPTY;
			end
		endfunction

		function void swap_ways(int a, int b);
			bit [63:0] k;
			int s;
			bit [15:0] m;
			bit [7:0] d;
			bit [1:0] t;
			k = keys[a]; s = scores[a]; m = moves[a]; d = depths[a]; t = bounds[a];
			keys[a] = keys[b]; scores[a] = scores[b]; moves[a] = moves[b];
			depths[a] = depths[b]; bounds[a] = bounds[b];
			keys[b] = k; scores[b] = s; moves[b] = m; depths[b] = d; bounds[b] = t;
		endfunction

		// Updates the table for one accepted input transfer and queues its answer, if it has one.
		function void note_transfer(bit [2:0] op, bit [63:0] key, bit [7:0] depth,
				bit [7:0] ply, shortint alpha, shortint beta, shortint value,
				bit [1:0] bound, bit [15:0] move);
			int base;
			int sc;
			int st;
			int used;
			tt_answer_t a;
			base = int'(key[9:0]) * 2;
			a = '{hit: 0, score: 0, best_move: 0, permille: 0};
			case (op)
				ttu_pkg::OP_PROBE, ttu_pkg::OP_LOOKUP: begin
					for (int i = 0; i < 2; i++) begin
						if (keys[base+i] == key) begin
							a.best_move = moves[base+i];
							if (op == ttu_pkg::OP_PROBE && depths[base+i] >= depth) begin
								sc = scores[base+i];
								if (sc == infinity) sc -= int'(ply);
								if (bounds[base+i] == ttu_pkg::BND_EXACT ||
										(bounds[base+i] == ttu_pkg::BND_UPPER && sc <= alpha) ||
										(bounds[base+i] == ttu_pkg::BND_LOWER && sc >= beta)) begin
									a.hit = 1;
									a.score = sc[15:0];
								end
							end
							break;
						end
					end
					pending.push_back(a);
				end
				ttu_pkg::OP_STORE: begin
					if (!(ply > 0 && value == 0)) begin
						st = value;
						if (st == infinity) begin
							st += int'(ply);
							if (st > 32767) st = 32767;
						end
						for (int i = 0; i < 2; i++) begin
							if (bounds[base+i] == ttu_pkg::BND_EMPTY || i == 1 ||
									keys[base+i] == key) begin
								bounds[base+i] = bound;
								scores[base+i] = st;
								depths[base+i] = depth;
								keys[base+i] = key;
								moves[base+i] = move;
								if (i == 1 && depths[base+1] > depths[base])
									swap_ways(base + 1, base);
								break;
							end
						end
					end
				end
				ttu_pkg::OP_CLEAR: wipe();
				ttu_pkg::OP_OCC: begin
					used = 0;
					foreach (keys[i]) if (keys[i] != 0) used++;
					a.permille = 10'((used * 1000) / NSLOTS);
					pending.push_back(a);
				end
				default: ;
			endcase
		endfunction

		// Compares one accepted output transfer with the oldest queued answer.
		function void check_transfer(bit hit, bit [47:0] data);
			tt_answer_t a;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result hit=%0d data=%h", $time, hit, data);
				errors++;
				return;
			end
			a = pending.pop_front();
			checked++;
			if (hit !== a.hit) begin
				$display("%0t: hit expected %0d actual %0d", $time, a.hit, hit);
				errors++;
			end
			if (data[15:0] !== a.score) begin
				$display("%0t: score expected %h actual %h", $time, a.score, data[15:0]);
				errors++;
			end
			if (data[31:16] !== a.best_move) begin
				$display("%0t: best_move expected %h actual %h", $time, a.best_move,
					data[31:16]);
				errors++;
			end
			if (data[41:32] !== a.permille) begin
				$display("%0t: permille expected %0d actual %0d", $time, a.permille,
					data[41:32]);
				errors++;
			end
			if (data[47:42] !== 6'd0) begin
				$display("%0t: fill expected 0 actual %h", $time, data[47:42]);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [151:0] s_tdata;
	logic [2:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;
	logic m_tuser;
	logic cfg_we;
	logic [ttu_pkg::INF_W-1:0] cfg_wdata;

	tt_scoreboard table_model;
	int send_idle;
	int recv_idle;
	int cycles;
	int stores;
	int probes;
	bit [63:0] key_pool[16];

	two_way_transposition_table_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_way_transposition_table_unit_test: errors");
			$finish;
		end
	end

	// Output side: random stalls, and a check of every transfer.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			table_model.check_transfer(m_tuser, m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_op(bit [2:0] op, bit [63:0] key, bit [7:0] depth, bit [7:0] ply,
			shortint alpha, shortint beta, shortint value, bit [1:0] bound,
			bit [15:0] move);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {6'd0, move, bound, value, beta, alpha, ply, depth, key};
		do @(posedge clk); while (!s_tready);
		table_model.note_transfer(op, key, depth, ply, alpha, beta, value, bound, move);
		if (op == ttu_pkg::OP_STORE) stores++;
		if (op == ttu_pkg::OP_PROBE) probes++;
	endtask

	// Waits for all answers, then long enough for a clear still in progress.
	task automatic settle();
		s_tvalid <= 0;
		while (table_model.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_infinity(bit [ttu_pkg::INF_W-1:0] v);
		settle();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		table_model.infinity = v;
	endtask

	function automatic bit [63:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 75) return key_pool[$urandom_range(15)];
		if (r < 80) return 64'd0;
		return {$urandom, $urandom};
	endfunction

	task automatic random_phase(int count);
		int r;
		bit [2:0] op;
		shortint value;
		bit [7:0] ply;
		bit [7:0] depth;
		// A few buckets shared by many keys keep both ways and the swap busy.
		for (int i = 0; i < 16; i++)
			key_pool[i] = {$urandom, 22'($urandom), 10'($urandom_range(3) * 257)};
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 45) op = ttu_pkg::OP_STORE;
			else if (r < 80) op = ttu_pkg::OP_PROBE;
			else if (r < 88) op = ttu_pkg::OP_LOOKUP;
			else if (r < 93) op = ttu_pkg::OP_OCC;
			else if (r < 95) op = ttu_pkg::OP_CLEAR;
			else op = 3'($urandom_range(7, 5));
			r = $urandom_range(99);
			if (r < 20) value = shortint'(table_model.infinity);
			else if (r < 30) value = 0;
			else value = shortint'($urandom);
			ply = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
			depth = ($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
			send_op(op, pick_key(), depth, ply, shortint'($urandom), shortint'($urandom),
				value, 2'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		table_model = new();
		table_model.wipe();
		table_model.infinity = ttu_pkg::INF_RESET;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		send_idle = 0;
		recv_idle = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// Directed part, default infinity score.
		send_op(ttu_pkg::OP_OCC, 0, 0, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_PROBE, 0, 0, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_STORE, 64'h5, 10, 0, 0, 0, 100, ttu_pkg::BND_EXACT, 16'hffff);
		send_op(ttu_pkg::OP_PROBE, 64'h5, 10, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_PROBE, 64'h5, 11, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_STORE, 64'h405, 20, 0, 0, 0, -50, ttu_pkg::BND_UPPER, 16'h1234);
		send_op(ttu_pkg::OP_PROBE, 64'h405, 20, 0, -50, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_PROBE, 64'h405, 0, 0, -51, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_STORE, 64'h805, 0, 7, 0, 0, 32000, ttu_pkg::BND_LOWER, 16'h0001);
		send_op(ttu_pkg::OP_PROBE, 64'h805, 0, 9, 0, 32767, 0, 0, 0);
		send_op(ttu_pkg::OP_STORE, 64'hffff_ffff_ffff_ffff, 255, 0, 0, 0, 32000,
			ttu_pkg::BND_LOWER, 16'h8000);
		send_op(ttu_pkg::OP_PROBE, 64'hffff_ffff_ffff_ffff, 255, 255, 0, -32768, 0, 0, 0);
		send_op(ttu_pkg::OP_STORE, 64'h77, 5, 3, 0, 0, 0, ttu_pkg::BND_EXACT, 16'h4444);
		send_op(ttu_pkg::OP_LOOKUP, 64'h77, 0, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_STORE, 64'h78, 5, 0, 0, 0, -32768, ttu_pkg::BND_EMPTY, 16'h5555);
		send_op(ttu_pkg::OP_PROBE, 64'h78, 0, 0, 32767, -32768, 0, 0, 0);
		send_op(ttu_pkg::OP_LOOKUP, 64'h405, 0, 0, 0, 0, 0, 0, 0);
		send_op(3'd5, 64'h5, 0, 0, 0, 0, 0, 0, 0);
		send_op(3'd6, 64'h5, 0, 0, 0, 0, 0, 0, 0);
		send_op(3'd7, 64'h5, 0, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_OCC, 0, 0, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_OCC, 0, 0, 0, 0, 0, 0, 0, 0);
		send_op(ttu_pkg::OP_PROBE, 64'h5, 0, 0, 0, 0, 0, 0, 0);

		// Random part over several infinity settings and idling patterns.
		write_infinity(15'd0);
		send_idle = 31;
		recv_idle = 58;
		random_phase(150);
		write_infinity(15'd32767);
		send_idle = 58;
		recv_idle = 31;
		random_phase(150);
		write_infinity(15'($urandom));
		send_idle = 0;
		recv_idle = 0;
		random_phase(150);

		s_tvalid <= 0;
		while (table_model.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d stores and %0d probes; %0d results checked.",
			stores, probes, table_model.checked);
		$display("Infinity scores 32000, 0, 32767 and a random value; three idling patterns.");
		if (table_model.errors == 0 && table_model.pending.size() == 0)
			$display("two_way_transposition_table_unit_test: clean");
		else
			$display("two_way_transposition_table_unit_test: errors");
		$finish;
	end

endmodule
